[rtl/csrd_pkg.sv]
// ----------------------------------------------------------------------------
// csrd_pkg
// Types, constants and the half to single conversion shared by the sparse
// row decompressor.
// ----------------------------------------------------------------------------
package csrd_pkg;

   localparam int unsigned LANES      = 8;
   localparam int unsigned LANE_BITS  = 3;
   localparam int unsigned GROUP_BITS = 4;    // group of 16 wraps to zero
   localparam int unsigned ROW_W      = 12;
   localparam int unsigned RW_W       = 13;
   localparam int unsigned COL_W      = 15;   // signed running column
   localparam int unsigned VCOL_W     = 10;
   localparam int unsigned ADDR_W     = 20;
   localparam int unsigned BASE_W     = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 280;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_WIDTH = 2'd0,
      CSR_DEST_BASE = 2'd1
   } csr_index_type;

   typedef logic [LANES-1:0][31:0] vector_type;

   typedef struct packed {
      logic              last;
      logic              err;
      vector_type        lanes;
      logic [ADDR_W-1:0] addr;
   } rsp_entry_type;

   // Exact fp16 -> fp32: subnormals normalized, NaN quieted.
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [9:0]  mnorm;
      logic [3:0]  sh;
      logic [7:0]  e;
      logic [30:0] res;
      ex    = h[14:10];
      man   = h[9:0];
      sh    = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (man[i]) sh = 4'(9 - i);
      end
      mnorm = 10'(man << (sh + 4'd1));
      e     = 8'(113 - 32'(sh) - 1);
      if (ex == 5'd0) begin
         if (man == 10'd0) res = 31'd0;
         else              res = {e, mnorm, 13'd0};
      end else if (ex == 5'h1f) begin
         res = {8'hff, man, 13'd0};
         if (man != 10'd0) res[22] = 1'b1;
      end else begin
         res = {8'({3'd0, ex} + 8'd112), man, 13'd0};
      end
      return {h[15], res};
   endfunction

endpackage

[rtl/sparse_csr_row_decompressor.sv]
// ----------------------------------------------------------------------------
// sparse_csr_row_decompressor
// Expands a stream of CSR row elements into dense 8-lane fp32 vector writes.
// ----------------------------------------------------------------------------
// One element item is taken per clock while req_tready is high. Each item
// updates the running column and the vector buffer in the accept cycle and
// queues zero, one or two write items into a 4-entry registered result queue
// that feeds rsp_. req_tready drops only while fewer than two queue entries
// are free, so with the sink ready the block runs at one element per cycle as
// long as elements cause no more than one write each on average; the sink's
// one write per cycle sets the pace otherwise. Configuration writes are
// always accepted and take effect from the following cycle.
module sparse_csr_row_decompressor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // row[11:0], value_half[27:12], gap[31:28]
   input  logic [csrd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // first_in_row
   input  logic                                 req_tuser,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // vector_address[19:0], lane_0..lane_7[275:20] (32 each), zero pad
   output logic [csrd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // column_error
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [csrd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [csrd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import csrd_pkg::*;

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = 2;
   localparam int unsigned CNT_W = 3;

   logic [RW_W-1:0]       row_width_ff, row_width_in;
   logic [BASE_W-1:0]     dest_base_ff, dest_base_in;
   logic signed [COL_W-1:0] col_ff, col_in;
   logic [VCOL_W-1:0]     vcol_ff, vcol_in;
   vector_type            buf_ff, buf_in;
   logic                  nz_ff, nz_in;
   logic [GROUP_BITS-1:0] grp_ff, grp_in;

   rsp_entry_type         q_ff [DEPTH];
   logic [PTR_W-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  accept, pop;
   logic [ROW_W-1:0]      row;
   logic [15:0]           half;
   logic [3:0]            gap;
   logic                  first, last;

   logic signed [COL_W-1:0] base_col, col;
   vector_type            base_buf;
   logic                  base_nz;
   logic [GROUP_BITS-1:0] base_grp, grp_inc;
   logic [VCOL_W-1:0]     base_vcol, new_vcol;
   logic                  err, vcol_cross, flush;
   logic [21:0]           row_prod;
   logic [ADDR_W-1:0]     addr_old, addr_new;
   rsp_entry_type         ent_a, ent_b, ent_0, ent_1;
   logic [1:0]            push_n;

   assign row   = req_tdata[11:0];
   assign half  = req_tdata[27:12];
   assign gap   = req_tdata[31:28];
   assign first = req_tuser;
   assign last  = req_tlast;

   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff <= CNT_W'(DEPTH - 2));
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      row_width_in = row_width_ff;
      dest_base_in = dest_base_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_WIDTH: row_width_in = csr_wdata[RW_W-1:0];
            CSR_DEST_BASE: dest_base_in = csr_wdata;
            default:       ;
         endcase
      end
   end

   // Element processing
   always_comb begin
      base_col  = first ? '1 : col_ff;
      base_vcol = first ? '0 : vcol_ff;
      base_buf  = first ? '0 : buf_ff;
      base_nz   = first ? 1'b0 : nz_ff;
      base_grp  = first ? '0 : grp_ff;

      col        = base_col + COL_W'(gap) + COL_W'(1);
      err        = col >= $signed({1'b0, row_width_ff});
      new_vcol   = VCOL_W'(col >>> LANE_BITS);
      vcol_cross = new_vcol > base_vcol;

      row_prod = row * 22'(row_width_ff >> LANE_BITS);
      addr_old = ADDR_W'(dest_base_ff) + ADDR_W'(row_prod) + ADDR_W'(base_vcol);
      addr_new = ADDR_W'(dest_base_ff) + ADDR_W'(row_prod) + ADDR_W'(new_vcol);

      col_in  = col_ff;
      vcol_in = vcol_ff;
      buf_in  = buf_ff;
      nz_in   = nz_ff;
      grp_in  = grp_ff;

      ent_a.addr  = addr_old;
      ent_a.lanes = base_buf;
      ent_a.err   = 1'b0;
      ent_a.last  = 1'b0;
      ent_b       = ent_a;

      grp_inc = base_grp + GROUP_BITS'(1);
      flush   = err || last || (grp_inc == '0);
      push_n  = 2'd0;

      if (accept) begin
         col_in  = base_col;
         vcol_in = base_vcol;
         buf_in  = base_buf;
         nz_in   = base_nz;
         if (!err) begin
            col_in = col;
            if (vcol_cross) begin
               vcol_in = new_vcol;
               if (base_nz) begin
                  push_n = 2'd1;
                  buf_in = '0;
                  nz_in  = 1'b0;
               end
            end
            if (half[14:0] != 15'd0) nz_in = 1'b1;
            buf_in[col[LANE_BITS-1:0]] = half_to_single(half);
         end
         grp_in = last ? '0 : grp_inc;
         if (flush) push_n = push_n + 2'd1;
      end

      // flush write carries the updated buffer at the current vector column
      ent_b.addr  = (!err && vcol_cross) ? addr_new : addr_old;
      ent_b.lanes = buf_in;
      ent_b.err   = err;
      ent_b.last  = 1'b1;
      ent_a.last  = !flush;

      ent_0 = (push_n == 2'd2) ? ent_a : (flush ? ent_b : ent_a);
      ent_1 = ent_b;
   end

   always_comb begin
      tail_in  = tail_ff + PTR_W'(push_n);
      head_in  = head_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= RW_W'(256);
         dest_base_ff <= '0;
         col_ff       <= '1;
         vcol_ff      <= '0;
         buf_ff       <= '0;
         nz_ff        <= 1'b0;
         grp_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
      end else begin
         row_width_ff <= row_width_in;
         dest_base_ff <= dest_base_in;
         col_ff       <= col_in;
         vcol_ff      <= vcol_in;
         buf_ff       <= buf_in;
         nz_ff        <= nz_in;
         grp_ff       <= grp_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) q_ff[tail_ff] <= ent_0;
      if (push_n == 2'd2) q_ff[PTR_W'(tail_ff + PTR_W'(1))] <= ent_1;
   end

   assign rsp_tdata = {4'd0, q_ff[head_ff].lanes, q_ff[head_ff].addr};
   assign rsp_tuser = q_ff[head_ff].err;
   assign rsp_tlast = q_ff[head_ff].last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("result queue overflow");
   a_room_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> count_ff <= CNT_W'(DEPTH - 2)) else $error("accept without room");
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      accept && err |-> push_n == 2'd1) else $error("dropped element wrote twice");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> count_ff == '0) else $error("queue not empty after reset");

endmodule
